// ===== design/plst_pkg.sv =====
// Shared types and codes for the positional list store.
package plst_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_DUMP   = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } state_t;

    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // controller to datapath
    typedef struct packed {
        logic exec;        // insert, delete or bad request
        logic dump_start;  // load first entry of a dump
        logic dump_next;   // load following entry of a dump
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;   // result register holds the final result of the item
        logic empty;  // list holds no entries
    } sts_t;

endpackage

// ===== design/plst_ctrl.sv =====
// Request sequencer: accepts items and walks results out to the consumer.
module plst_ctrl
    import plst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    output logic                out_valid,
    input  logic                out_ready,
    output cmd_t                cmd,
    input  sts_t                sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == REQ_DUMP)
                    begin
                        // dump of an empty list gives nothing
                        if (!sts.empty)
                        begin
                            cmd.dump_start = 1'b1;
                            state_next     = S_RESULT;
                        end
                    end
                    else
                    begin
                        cmd.exec   = 1'b1;
                        state_next = S_RESULT;
                    end
                end
            end
            S_RESULT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.dump_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/plst_dpath.sv =====
// Entry store with parallel shift, entry count and result registers.
module plst_dpath
    import plst_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [1:0]          req_type,
    input  logic [POS_W-1:0]    position,
    input  logic [VALUE_W-1:0]  value,
    output logic [1:0]          status,
    output logic [VALUE_W-1:0]  entry_value,
    output logic [POS_W-1:0]    entry_position,
    output logic [COUNT_W-1:0]  count,
    output logic                last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [DATA_W-1:0]  entries_reg  [DEPTH];
    logic [DATA_W-1:0]  entries_next [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic [CNT_W-1:0]   rd_sel;
    logic [CNT_W-1:0]   rd_pos;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic [VALUE_W-1:0] entry_value_reg;
    logic [POS_W-1:0]   entry_position_reg;
    logic               last_reg;

    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   slot;
    logic               pos_zero;
    logic               ins_ok;
    logic               del_ok;
    logic               full;
    logic               do_ins;
    logic               do_del;

    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign slot     = pos_ext - CMP_W'(1);
    assign pos_zero = (position == '0);
    assign ins_ok   = !pos_zero && (pos_ext <= cnt_ext + CMP_W'(1));
    assign del_ok   = !pos_zero && (pos_ext <= cnt_ext);
    assign full     = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        do_ins      = 1'b0;
        do_del      = 1'b0;
        status_next = ST_BADPOS;
        unique case (req_type)
            REQ_INSERT:
            begin
                // bad position wins over full store
                if (!ins_ok)
                begin
                    status_next = ST_BADPOS;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_DONE;
                    do_ins      = cmd.exec;
                end
            end
            REQ_DELETE:
            begin
                if (del_ok)
                begin
                    status_next = ST_DONE;
                    do_del      = cmd.exec;
                end
            end
            default:
            begin
                status_next = ST_BADPOS;
            end
        endcase
    end

    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        if (do_ins)
        begin
            for (int i = 1; i < DEPTH; i++)
            begin
                if (CMP_W'(i) > slot)
                begin
                    entries_next[i] = entries_reg[i-1];
                end
            end
            for (int i = 0; i < DEPTH; i++)
            begin
                if (CMP_W'(i) == slot)
                begin
                    entries_next[i] = DATA_W'(value);
                end
            end
            count_next = count_reg + CNT_W'(1);
        end
        if (do_del)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (CMP_W'(i) >= slot)
                begin
                    entries_next[i] = entries_reg[i+1];
                end
            end
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign rd_sel = cmd.dump_start ? '0 : rd_idx_reg + CNT_W'(1);
    assign rd_pos = rd_sel + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            last_reg   <= 1'b1;
            rd_idx_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.exec)
            begin
                last_reg <= 1'b1;
            end
            else if (cmd.dump_start || cmd.dump_next)
            begin
                last_reg   <= (rd_pos == count_reg);
                rd_idx_reg <= rd_sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg         <= status_next;
            entry_value_reg    <= '0;
            entry_position_reg <= '0;
        end
        else if (cmd.dump_start || cmd.dump_next)
        begin
            status_reg         <= ST_DONE;
            entry_value_reg    <= VALUE_W'(entries_reg[rd_sel[IDX_W-1:0]]);
            entry_position_reg <= POS_W'(rd_pos);
        end
    end

    assign sts.last       = last_reg;
    assign sts.empty      = (count_reg == '0);
    assign status         = status_reg;
    assign entry_value    = entry_value_reg;
    assign entry_position = entry_position_reg;
    assign count          = COUNT_W'(count_reg);
    assign last           = last_reg;

endmodule

// ===== design/positional_list_store.sv =====
// Insert or delete: the result is registered and shown in the cycle after the item is
// accepted; the next item is taken once the result is out.
// Dump of N entries: N results, one per cycle while out_ready is high, read from the
// shift-register store; a dump of an empty list finishes in its accept cycle.
// Shifting on insert/delete moves all entries in parallel in the accept cycle.
// Reset clears the entry count and the sequencer; store contents are not cleared.
module positional_list_store
    import plst_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [POS_W-1:0]    position,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [VALUE_W-1:0]  entry_value,
    output logic [POS_W-1:0]    entry_position,
    output logic [COUNT_W-1:0]  count,
    output logic                last
);

    cmd_t cmd;
    sts_t sts;

    plst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    plst_dpath #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .position       (position),
        .value          (value),
        .status         (status),
        .entry_value    (entry_value),
        .entry_position (entry_position),
        .count          (count),
        .last           (last)
    );

endmodule

// ===== design/plst_chk.sv =====
// Port-level checks for the positional list store, bound to the top level.
module plst_chk
    import plst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [POS_W-1:0]    position,
    input  logic [VALUE_W-1:0]  value,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [1:0]          status,
    input  logic [VALUE_W-1:0]  entry_value,
    input  logic [POS_W-1:0]    entry_position,
    input  logic [COUNT_W-1:0]  count,
    input  logic                last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(entry_value) && $stable(entry_position)
            && $stable(count) && $stable(last))
        else $error("stalled result changed");

    // one item at a time: no intake while a result is pending
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    // a dump keeps going until its last entry
    a_dump_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && !in_ready)
        else $error("dump stopped before its last entry");

    // error results are single results
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> last && entry_position == '0)
        else $error("error result not final");

    // a dumped entry lies inside the list
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_position != '0 |-> entry_position <= count)
        else $error("dumped position beyond count");

endmodule

bind positional_list_store plst_chk u_plst_chk (.*);
